>>> design/nearest_centroid_classifier_assert.svh
// assertion macros used by the checker file
`ifndef NEAREST_CENTROID_CLASSIFIER_ASSERT_SVH
`define NEAREST_CENTROID_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define NCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ncc check failed");

// next-cycle implication
`define NCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ncc check failed");

`endif

>>> design/ncc_pkg.sv
// shared codes and types of the nearest centroid classifier
package ncc_pkg;

    localparam logic CMD_CENTROID = 1'b0;
    localparam logic CMD_SAMPLE   = 1'b1;

    localparam logic CFG_POWER = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam logic [2:0] POWER_RESET = 3'd2;
    localparam logic [4:0] COUNT_RESET = 5'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_POW,
        S_ACC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic done;
        logic sat;
    } t_term_stat;

endpackage

>>> design/ncc_cell.sv
// one cell of the accumulator chain: distance and overflow mark of one cluster
module ncc_cell #(
    parameter int DIST_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic [DIST_BITS-1:0] i_acc,
    input  logic                 i_mark,
    output logic [DIST_BITS-1:0] o_acc,
    output logic                 o_mark
);

    logic [DIST_BITS-1:0] r_acc;
    logic                 r_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_mark <= 1'b0;
        end else if (i_shift) begin
            r_acc  <= i_acc;
            r_mark <= i_mark;
        end
    end

    assign o_acc  = r_acc;
    assign o_mark = r_mark;

endmodule

>>> design/ncc_term_unit.sv
// iterative power unit: raises a magnitude to a power, one multiply per cycle, flagging overflow
module ncc_term_unit #(
    parameter int MAG_W     = 17,
    parameter int DIST_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [MAG_W-1:0]      i_mag,
    input  logic [2:0]            i_power,
    output logic [MAG_W-1:0]      o_mag,
    output logic [DIST_BITS-1:0]  o_term,
    output ncc_pkg::t_term_stat   o_stat
);

    localparam int PW = DIST_BITS + MAG_W;

    logic [2:0]           r_cnt;
    logic [DIST_BITS-1:0] r_term;
    logic [MAG_W-1:0]     r_mag;
    logic                 r_sat;
    logic [PW-1:0]        prod;

    assign prod = PW'(r_term) * PW'(r_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_power;
        end else if (r_cnt != 3'd0) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_term <= DIST_BITS'(1);
            r_mag  <= i_mag;
            r_sat  <= 1'b0;
        end else if (r_cnt != 3'd0) begin
            r_term <= prod[DIST_BITS-1:0];
            r_sat  <= r_sat | (|prod[PW-1:DIST_BITS]);
        end
    end

    assign o_mag       = r_mag;
    assign o_term      = r_term;
    assign o_stat.done = (r_cnt == 3'd0);
    assign o_stat.sat  = r_sat;

endmodule

>>> design/nearest_centroid_classifier.sv
// nearest centroid classifier top level: table, sequencer, term unit and cell chain
//
// Input channel (valid/ready) carries one item per transfer. A centroid item
// (cmd 0) writes one table coordinate. A sample item (cmd 1) visits every
// cluster in turn through a rotating chain of accumulator cells and one shared
// power unit, stepping per cluster through table read, difference, power
// iterations and accumulate; the input is not ready again until the pass ends.
// On a sample item marked last the same pass picks the winner and clears the
// chain, and the finish state loads the result into the output register once
// that register is free. The output channel (valid/ready) holds the result
// until it is taken; a further item is accepted while it waits, and only the
// next final result stalls until the register is free.
// Configuration writes take effect at once; the user makes them only while
// idle, which the block itself does not enforce. Reset clears the accumulators,
// overflow marks, sequencer and output valid and sets distance_power 2 and
// cluster_count 2; the centroid table is not cleared and must be written before use.
module nearest_centroid_classifier #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_AXES     = 8,
    parameter int COORD_BITS   = 16,
    parameter int DIST_BITS    = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_addr,
    input  logic [4:0]                   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_cmd,
    input  logic [3:0]                   i_cluster_index,
    input  logic [2:0]                   i_axis,
    input  logic signed [COORD_BITS-1:0] i_coord_value,
    input  logic                         i_last_axis,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [3:0]                   o_winner,
    output logic [DIST_BITS-1:0]         o_best_distance,
    output logic                         o_saturated
);

    localparam int DEPTH = MAX_CLUSTERS * MAX_AXES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int MAG_W = COORD_BITS + 1;
    localparam int PW    = DIST_BITS + MAG_W;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    ncc_pkg::t_state r_state, n_state;

    logic [2:0]            r_power;
    logic [4:0]            r_count;
    logic [2:0]            r_axis;
    logic [COORD_BITS-1:0] r_value;
    logic                  r_last;
    logic [IW-1:0]         r_j;
    logic [COORD_BITS-1:0] r_mem [DEPTH];
    logic [COORD_BITS-1:0] r_rd;
    logic [IW-1:0]         r_best_i;
    logic [DIST_BITS-1:0]  r_best_d;
    logic                  r_best_sat;
    logic                  r_out_valid;
    logic [3:0]            r_winner;
    logic [DIST_BITS-1:0]  r_dist;
    logic                  r_sat;

    logic rd_en, unit_load, shift, fin_load, in_acc, wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic axis_ok, j_in, j_end;
    logic [MAG_W-1:0] diff, mag_in, mag;
    logic [DIST_BITS-1:0] term;
    ncc_pkg::t_term_stat stat;
    logic [PW-1:0] mag_ext;
    logic [DIST_BITS:0] sum;
    logic [DIST_BITS-1:0] new_acc, upd_acc, tail_acc;
    logic new_ovf, upd_mark, tail_mark, active;
    logic [DIST_BITS-1:0] chain_acc  [MAX_CLUSTERS];
    logic                 chain_mark [MAX_CLUSTERS];

    assign in_acc  = i_in_valid && o_in_ready;
    assign wr_en   = in_acc && (i_cmd == ncc_pkg::CMD_CENTROID)
                     && (32'(i_cluster_index) < MAX_CLUSTERS) && (32'(i_axis) < MAX_AXES);
    assign wr_addr = AW'(32'(i_cluster_index) * MAX_AXES + 32'(i_axis));
    assign rd_addr = AW'(32'(r_j) * MAX_AXES + 32'(r_axis));
    assign axis_ok = 32'(r_axis) < MAX_AXES;
    assign j_in    = (r_j == '0) || (32'(r_j) < 32'(r_count));
    assign j_end   = (r_j == IW'(MAX_CLUSTERS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power <= ncc_pkg::POWER_RESET;
            r_count <= ncc_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ncc_pkg::CFG_POWER: r_power <= i_cfg_wdata[2:0];
                ncc_pkg::CFG_COUNT: r_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_coord_value;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_axis  <= i_axis;
            r_value <= i_coord_value;
            r_last  <= i_last_axis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ncc_pkg::S_IDLE;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_j <= '0;
            end else if (shift) begin
                r_j <= j_end ? '0 : r_j + IW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ncc_pkg::S_IDLE: begin
                if (i_in_valid && i_cmd == ncc_pkg::CMD_SAMPLE) begin
                    n_state = ncc_pkg::S_READ;
                end
            end
            ncc_pkg::S_READ: n_state = ncc_pkg::S_DIFF;
            ncc_pkg::S_DIFF: n_state = ncc_pkg::S_POW;
            ncc_pkg::S_POW: begin
                if (stat.done) begin
                    n_state = ncc_pkg::S_ACC;
                end
            end
            ncc_pkg::S_ACC: begin
                if (!j_end) begin
                    n_state = ncc_pkg::S_READ;
                end else if (r_last) begin
                    n_state = ncc_pkg::S_FIN;
                end else begin
                    n_state = ncc_pkg::S_IDLE;
                end
            end
            ncc_pkg::S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ncc_pkg::S_IDLE;
                end
            end
            default: n_state = ncc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        unit_load  = 1'b0;
        shift      = 1'b0;
        fin_load   = 1'b0;
        case (r_state)
            ncc_pkg::S_IDLE: o_in_ready = 1'b1;
            ncc_pkg::S_READ: rd_en = 1'b1;
            ncc_pkg::S_DIFF: unit_load = 1'b1;
            ncc_pkg::S_POW:  ;
            ncc_pkg::S_ACC:  shift = 1'b1;
            ncc_pkg::S_FIN:  fin_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // absolute difference of sample and centroid
    assign diff   = {r_value[COORD_BITS-1], r_value} - {r_rd[COORD_BITS-1], r_rd};
    assign mag_in = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;

    ncc_term_unit #(
        .MAG_W     (MAG_W),
        .DIST_BITS (DIST_BITS)
    ) u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (unit_load),
        .i_mag   (mag_in),
        .i_power (r_power),
        .o_mag   (mag),
        .o_term  (term),
        .o_stat  (stat)
    );

    assign mag_ext = PW'(mag);
    assign sum     = {1'b0, chain_acc[0]} + {1'b0, term};

    always_comb begin
        if (r_power == 3'd0) begin
            new_ovf = |mag_ext[PW-1:DIST_BITS];
            if (new_ovf) begin
                new_acc = DIST_MAX;
            end else if (mag_ext[DIST_BITS-1:0] > chain_acc[0]) begin
                new_acc = mag_ext[DIST_BITS-1:0];
            end else begin
                new_acc = chain_acc[0];
            end
        end else begin
            new_ovf = stat.sat | sum[DIST_BITS];
            new_acc = new_ovf ? DIST_MAX : sum[DIST_BITS-1:0];
        end
    end

    assign active    = j_in && axis_ok && !chain_mark[0];
    assign upd_acc   = active ? new_acc : chain_acc[0];
    assign upd_mark  = chain_mark[0] | (active & new_ovf);
    assign tail_acc  = r_last ? '0 : upd_acc;
    assign tail_mark = r_last ? 1'b0 : upd_mark;

    // rotating chain: cell k takes from cell k+1, the last cell from the update
    for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
        if (k == MAX_CLUSTERS - 1) begin : g_tail
            ncc_cell #(.DIST_BITS(DIST_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_acc   (tail_acc),
                .i_mark  (tail_mark),
                .o_acc   (chain_acc[k]),
                .o_mark  (chain_mark[k])
            );
        end else begin : g_mid
            ncc_cell #(.DIST_BITS(DIST_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_acc   (chain_acc[k+1]),
                .i_mark  (chain_mark[k+1]),
                .o_acc   (chain_acc[k]),
                .o_mark  (chain_mark[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift && j_in) begin
            if (r_j == '0 || upd_acc < r_best_d) begin
                r_best_i <= r_j;
                r_best_d <= upd_acc;
            end
            r_best_sat <= ((r_j == '0) ? 1'b0 : r_best_sat) | upd_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_winner <= 4'(r_best_i);
            r_dist   <= r_best_d;
            r_sat    <= r_best_sat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_winner        = r_winner;
    assign o_best_distance = r_dist;
    assign o_saturated     = r_sat;

endmodule

>>> design/ncc_checker.sv
// port-level checks of the nearest centroid classifier and their binding
`include "nearest_centroid_classifier_assert.svh"

module ncc_checker #(
    parameter int DIST_BITS = 48
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_cmd,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [3:0]           i_winner,
    input logic [DIST_BITS-1:0] i_dist,
    input logic                 i_sat
);

    `NCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `NCC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_winner) && $stable(i_dist) && $stable(i_sat))
    `NCC_ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && i_cmd == ncc_pkg::CMD_SAMPLE, !i_in_ready)
    `NCC_ASSERT_SAME(a_result_after_work, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready))

endmodule

bind nearest_centroid_classifier ncc_checker #(.DIST_BITS(DIST_BITS)) u_ncc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_cmd       (i_cmd),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_winner    (o_winner),
    .i_dist      (o_best_distance),
    .i_sat       (o_saturated)
);
